@@ rtl/pccd_pkg.sv @@
// ----------------------------------------------------------------------------
// pccd_pkg
// Shared types and constants of the pairwise circle collision detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pccd_pkg;

    // field widths
    localparam int POS_W          = 16;
    localparam int RAD_W          = 12;
    localparam int SLOT_W         = 4;
    localparam int DEF_MAX_SHAPES = 16;

    // derived arithmetic widths
    localparam int DIFF_W = POS_W + 1;        // signed difference
    localparam int ADIF_W = POS_W;            // magnitude of the difference
    localparam int DSQ_W  = 2 * ADIF_W;       // one squared axis distance
    localparam int DSUM_W = DSQ_W + 1;        // sum of both axes
    localparam int RSUM_W = RAD_W + 1;        // summed radii
    localparam int RSQ_W  = 2 * RSUM_W;       // squared summed radii

    // one stored shape
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic        [RAD_W-1:0] r;
        logic                    coll;
    } t_shape;

    // probe shape travelling along the chain
    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic        [RAD_W-1:0] r;
    } t_probe;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;       // store the incoming shape
        logic clr_all;  // clear the hit flag for a new probe
        logic clr_one;  // hit flag reported, drop it
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/pairwise_circle_collision_detector.sv @@
// ----------------------------------------------------------------------------
// pairwise_circle_collision_detector
// Broad-phase circle overlap test over one frame of up to MAX_SHAPES shapes.
// ----------------------------------------------------------------------------
// Each accepted shape takes the next slot of the frame (start_frame restarts
// at slot 0; a shape arriving with every slot taken is dropped). A collidable
// shape is sent as a probe down a chain of MAX_SHAPES cells, one cell per
// cycle, each cell holding one stored shape and testing it in two stages; the
// pairs found are then reported one per cycle while the output is taken, in
// ascending earlier slot, the final one flagged with last_of_run. A collidable
// shape keeps the input busy while the probe walks the chain and its pairs
// are reported; a shape that is not collidable or is dropped leaves the input
// ready. The output register lets the next request be accepted while a
// reported pair still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_circle_collision_detector
    import pccd_pkg::*;
#(
    parameter int MAX_SHAPES = DEF_MAX_SHAPES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request channel
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_start_frame,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    input  wire logic        [RAD_W-1:0] i_radius,
    input  wire logic                    i_collidable,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic             [SLOT_W-1:0] o_earlier_slot,
    output logic             [SLOT_W-1:0] o_new_slot,
    output logic                         o_last_of_run
);

    localparam int IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CNT_W = $clog2(MAX_SHAPES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_slot,  n_slot;
    logic             n_inj_valid;
    t_probe           r_inj;

    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [CNT_W-1:0] r_out_slot;
    logic             r_out_last;

    logic             w_in_fire;
    logic [CNT_W-1:0] w_base;
    logic             w_full;
    logic             w_store;
    logic             w_launch;
    logic             w_can_load;
    logic             w_load;

    t_shape                 w_shape;
    t_probe                 w_chain [MAX_SHAPES+1];
    t_cell_ctl              w_ctl   [MAX_SHAPES];
    logic [MAX_SHAPES-1:0]  w_hits;
    logic [MAX_SHAPES-1:0]  w_pick_oh;
    logic [IDX_W-1:0]       w_pick_idx;
    logic                   w_any_hit;
    logic                   w_more;

    // request handshake and slot assignment
    assign o_ready   = (r_state == ST_IDLE);
    assign w_in_fire = i_valid && o_ready;
    assign w_base    = i_start_frame ? '0 : r_count;
    assign w_full    = (w_base == CNT_W'(MAX_SHAPES));
    assign w_store   = w_in_fire && !w_full;
    assign w_launch  = w_store && i_collidable;

    assign w_shape.x    = i_pos_x;
    assign w_shape.z    = i_pos_z;
    assign w_shape.r    = i_radius;
    assign w_shape.coll = i_collidable;

    // lowest pending hit
    always_comb begin
        w_pick_idx = '0;
        for (int i = MAX_SHAPES - 1; i >= 0; i--) begin
            if (w_hits[i]) begin
                w_pick_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SHAPES; i++) begin
            w_pick_oh[i] = w_hits[i] && (w_pick_idx == IDX_W'(i));
        end
    end

    assign w_any_hit  = |w_hits;
    assign w_more     = |(w_hits & ~w_pick_oh);
    assign w_can_load = !r_out_valid || i_ready;
    assign w_load     = (r_state == ST_EMIT) && w_any_hit && w_can_load;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_slot      = r_slot;
        n_inj_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_store) begin
                    n_count = w_base + CNT_W'(1);
                    n_slot  = w_base;
                end
                if (w_launch) begin
                    n_inj_valid = 1'b1;
                    n_state     = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // probe leaves the last cell as that cell's compare lands
                if (w_chain[MAX_SHAPES].valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_any_hit || (w_load && !w_more)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    // probe injected at the head of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.valid <= 1'b0;
        end else begin
            r_inj.valid <= n_inj_valid;
        end
        if (w_launch) begin
            r_inj.x <= i_pos_x;
            r_inj.z <= i_pos_z;
            r_inj.r <= i_radius;
        end
    end

    // chain of cells
    assign w_chain[0] = r_inj;

    for (genvar g = 0; g < MAX_SHAPES; g++) begin : g_cell
        assign w_ctl[g].wr      = w_store && (w_base == CNT_W'(g));
        assign w_ctl[g].clr_all = w_launch;
        assign w_ctl[g].clr_one = w_load && w_pick_oh[g];

        pccd_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_shape (w_shape),
            .i_slot  (r_slot),
            .i_probe (w_chain[g]),
            .o_probe (w_chain[g+1]),
            .o_hit   (w_hits[g])
        );
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx  <= w_pick_idx;
            r_out_slot <= r_slot;
            r_out_last <= !w_more;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_earlier_slot = SLOT_W'(r_out_idx);
    assign o_new_slot     = SLOT_W'(r_out_slot);
    assign o_last_of_run  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/pccd_cell.sv @@
// ----------------------------------------------------------------------------
// pccd_cell
// One slot of the chain: holds a stored shape, tests the passing probe against
// it over two stages and keeps a hit flag until it is reported or a new probe starts.
// ----------------------------------------------------------------------------
`default_nettype none

module pccd_cell
    import pccd_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_shape           i_shape,
    input  wire logic [CNT_W-1:0] i_slot,
    input  wire t_probe           i_probe,
    output t_probe                o_probe,
    output logic                  o_hit
);

    // stored shape, undefined until written
    t_shape r_store;

    t_probe r_probe;
    logic   n_probe_valid;

    logic               r_cand;
    logic [DSQ_W-1:0]   r_sqx;
    logic [DSQ_W-1:0]   r_sqz;
    logic [RSQ_W-1:0]   r_rsq;
    logic               r_hit;

    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dz;
    logic        [ADIF_W-1:0] w_adx;
    logic        [ADIF_W-1:0] w_adz;
    logic        [RSUM_W-1:0] w_rsum;
    logic                     w_live;
    logic        [DSUM_W-1:0] w_dsum;
    logic                     w_overlap;

    // shape store
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_store <= i_shape;
        end
    end

    // probe hand-off to the next cell
    assign n_probe_valid = i_probe.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe_valid;
        end
        r_probe.x <= i_probe.x;
        r_probe.z <= i_probe.z;
        r_probe.r <= i_probe.r;
    end

    assign o_probe = r_probe;

    // stage 1: distances and squares
    assign w_dx   = DIFF_W'(i_probe.x) - DIFF_W'(r_store.x);
    assign w_dz   = DIFF_W'(i_probe.z) - DIFF_W'(r_store.z);
    assign w_adx  = (w_dx < 0) ? ADIF_W'(-w_dx) : ADIF_W'(w_dx);
    assign w_adz  = (w_dz < 0) ? ADIF_W'(-w_dz) : ADIF_W'(w_dz);
    assign w_rsum = RSUM_W'(i_probe.r) + RSUM_W'(r_store.r);
    assign w_live = (CNT_W'(CELL_IDX) < i_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= 1'b0;
        end else begin
            r_cand <= i_probe.valid && w_live && r_store.coll;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sqx <= DSQ_W'(w_adx) * DSQ_W'(w_adx);
        r_sqz <= DSQ_W'(w_adz) * DSQ_W'(w_adz);
        r_rsq <= RSQ_W'(w_rsum) * RSQ_W'(w_rsum);
    end

    // stage 2: overlap compare
    assign w_dsum    = DSUM_W'(r_sqx) + DSUM_W'(r_sqz);
    assign w_overlap = (w_dsum < DSUM_W'(r_rsq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.clr_all || i_ctl.clr_one) begin
            r_hit <= 1'b0;
        end else if (r_cand && w_overlap) begin
            r_hit <= 1'b1;
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire
